// File: rtl/etc_pkg.sv
`timescale 1ns / 1ps

package etc_pkg;

  // operand and result width
  localparam int unsigned WIDTH = 16;

  typedef logic [WIDTH-1:0] word_t;

  // status returned by the coprimality unit
  typedef struct packed {
    logic done;     // one-cycle pulse, test finished
    logic coprime;  // gcd of the two operands is one
  } gcd_sts_t;

endpackage

// File: rtl/euler_totient_counter_core.sv
`timescale 1ns / 1ps

// euler totient by direct count
// input channel: in_valid_i / in_stall_o, one beat carries number_i
// output channel: out_valid_o / out_stall_i, one beat carries totient_o
// a beat moves on a rising edge with valid high and stall low
// one result beat per input beat, in order
// each candidate i in 2..n-1 goes through a shared binary gcd unit that does
// one shift or one compare-and-subtract per cycle; a candidate with i and n
// both even is settled without gcd steps, otherwise it takes k gcd steps,
// and k is at most 4*WIDTH-4 since every subtract is followed by a shift
// n of 0, 1 or 2 has no candidates
// in_stall_o stays high from accept until the result lands in the output
// register; the output register holds a result while the receiver stalls,
// and the next beat can be taken while it waits there
// reset clears the sequencer and the output valid; no item survives it
module euler_totient_counter_core import etc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [WIDTH-1:0]  number_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WIDTH-1:0]  totient_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_FLUSH
  } state_e;

  localparam word_t One = word_t'(1);
  localparam word_t Two = word_t'(2);

  state_e   state_q;
  word_t    n_q;      // value under test
  word_t    i_q;      // current candidate
  word_t    cnt_q;    // running count, starts at one for the value 1
  logic     out_valid_q;
  word_t    totient_q;

  logic     in_fire;
  logic     out_free;
  logic     gcd_start;
  gcd_sts_t gcd_sts;

  assign in_fire   = in_valid_i && !in_stall_o;
  // output register can take a new result this cycle
  assign out_free  = !out_valid_q || !out_stall_i;
  assign gcd_start = (state_q == S_START);

  etc_gcd_unit u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (i_q),
    .b_i     (n_q),
    .sts_o   (gcd_sts)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces a taken one in the same cycle
      if ((state_q == S_FLUSH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            // nothing to test for small n
            state_q <= (number_i <= Two) ? S_FLUSH : S_START;
          end
        end
        S_START: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (gcd_sts.done) begin
            // last candidate is n-1
            state_q <= (i_q == (n_q - One)) ? S_FLUSH : S_START;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      n_q   <= number_i;
      i_q   <= Two;
      cnt_q <= One;
    end else if ((state_q == S_WAIT) && gcd_sts.done) begin
      i_q <= i_q + One;
      if (gcd_sts.coprime) begin
        cnt_q <= cnt_q + One;
      end
    end
    if ((state_q == S_FLUSH) && out_free) begin
      totient_q <= cnt_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign totient_o   = totient_q;

  // an accepted beat makes the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("input accepted but block not busy");

  // the gcd unit only reports while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_sts.done |-> (state_q == S_WAIT))
    else $error("gcd result outside wait state");

  // a totient is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (totient_o != '0))
    else $error("zero totient delivered");

  // the count never passes the candidate being tested
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_START) || (state_q == S_WAIT)) |-> (cnt_q < i_q))
    else $error("count ran ahead of candidate");

endmodule

// File: rtl/etc_gcd_unit.sv
`timescale 1ns / 1ps

module etc_gcd_unit import etc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  word_t    a_i,
  input  word_t    b_i,
  output gcd_sts_t sts_o
);

  localparam word_t One = word_t'(1);

  logic  busy_q;
  logic  done_q;
  logic  coprime_q;
  word_t a_q;
  word_t b_q;

  // shared compare and subtract
  logic  a_gt_b;
  word_t big;
  word_t little;
  word_t diff;

  assign a_gt_b = a_q > b_q;
  assign big    = a_gt_b ? a_q : b_q;
  assign little = a_gt_b ? b_q : a_q;
  assign diff   = big - little;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      coprime_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // both even: common factor two, no need to iterate
        if (!a_i[0] && !b_i[0]) begin
          done_q    <= 1'b1;
          coprime_q <= 1'b0;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q && a_q[0] && b_q[0] && (a_q == b_q)) begin
        busy_q    <= 1'b0;
        done_q    <= 1'b1;
        coprime_q <= (a_q == One);
      end
    end
  end

  // binary gcd, one shift or one subtract per cycle while busy
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q != b_q) begin
        if (a_gt_b) begin
          a_q <= diff;
        end else begin
          b_q <= diff;
        end
      end
    end
  end

  assign sts_o.done    = done_q;
  assign sts_o.coprime = coprime_q;

endmodule
